// ===== rtl/ttce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_pkg
// shared types, constants and helper functions of the text terminal cursor engine
// ----------------------------------------------------------------------------
package ttce_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int SCREEN_WIDTH = 1024;
    localparam int FONT_SCALE   = 2;
    localparam int CELL         = 8 * FONT_SCALE;
    localparam int LA_LEN       = 11;
    localparam int CNT_W        = 4;
    localparam int X_W          = 10;
    localparam int Y_W          = 16;
    localparam int COLOR_W      = 24;
    localparam int CH_W         = 8;
    localparam int LS_W         = 8;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CH_W-1:0] CH_BS     = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPACING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_COLOR = 2'd1;

    localparam logic [LS_W-1:0]    LS_RESET    = 8'd2;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ACT_CHAR,
        ACT_WAIT,
        ACT_DROP,
        ACT_COLOR
    } t_act;

    typedef enum logic [1:0] {
        HK_OTHER,
        HK_NL,
        HK_BS,
        HK_TAB
    } t_head_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_CLEAR,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_cursor;

    typedef struct packed {
        logic               kind;
        logic [X_W-1:0]     x_pos;
        logic [Y_W-1:0]     y_pos;
        logic [CH_W-1:0]    glyph;
        logic [COLOR_W-1:0] color;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic append;
        logic consume1;
        logic consume_all;
        logic load_color;
        logic do_nl;
        logic do_glyph;
        logic bs_start;
        logic walk;
        logic emit_clear;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic       count_zero;
        t_act       act;
        t_head_kind head_kind;
        logic       full;
        logic       fill_zero;
        logic       walk_done;
        logic       slot_ok;
        logic       out_free;
        logic       pend_valid;
    } t_stat;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [CH_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_cursor step_cursor(input t_cursor c, input logic nl,
                                            input logic [LS_W-1:0] ls);
        t_cursor      r;
        logic [X_W:0] ahead;
        r     = c;
        ahead = '0;
        if (nl) begin
            r.x = '0;
            r.y = c.y + Y_W'(CELL) + Y_W'(ls);
        end else begin
            r.x   = c.x + X_W'(CELL);
            ahead = {1'b0, r.x} + (X_W+1)'(CELL);
            if (ahead >= (X_W+1)'(SCREEN_WIDTH)) begin
                r.x = '0;
                r.y = c.y + Y_W'(CELL) + Y_W'(ls);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ttce_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_in_if
// character input channel: valid, ready, character and end-of-string flag
// ----------------------------------------------------------------------------
interface ttce_in_if;
    logic                      valid;
    logic                      ready;
    logic [ttce_pkg::CH_W-1:0] ch;
    logic                      last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ttce_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_out_if
// draw command output channel
// ----------------------------------------------------------------------------
interface ttce_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [ttce_pkg::X_W-1:0]     x_pos;
    logic [ttce_pkg::Y_W-1:0]     y_pos;
    logic [ttce_pkg::CH_W-1:0]    glyph;
    logic [ttce_pkg::COLOR_W-1:0] color;
    logic                         last_result;

    modport source (output valid, output kind, output x_pos, output y_pos,
                    output glyph, output color, output last_result, input ready);
    modport sink   (input valid, input kind, input x_pos, input y_pos,
                    input glyph, input color, input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/ttce_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module ttce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ttce_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_ctrl
// sequencer: walks the lookahead window head by head and issues datapath commands
// ----------------------------------------------------------------------------
module ttce_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire ttce_pkg::t_stat i_stat,
    output ttce_pkg::t_cmd       o_cmd
);
    ttce_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ttce_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.append = 1'b1;
                    n_state      = ttce_pkg::ST_SCAN;
                end
            end
            ttce_pkg::ST_SCAN: begin
                if (i_stat.count_zero) begin
                    n_state = ttce_pkg::ST_FLUSH;
                end else begin
                    unique case (i_stat.act)
                        ttce_pkg::ACT_WAIT:  n_state = ttce_pkg::ST_FLUSH;
                        ttce_pkg::ACT_DROP:  o_cmd.consume1 = 1'b1;
                        ttce_pkg::ACT_COLOR: begin
                            o_cmd.load_color  = 1'b1;
                            o_cmd.consume_all = 1'b1;
                        end
                        ttce_pkg::ACT_CHAR: begin
                            unique case (i_stat.head_kind)
                                ttce_pkg::HK_NL: begin
                                    o_cmd.do_nl    = 1'b1;
                                    o_cmd.consume1 = 1'b1;
                                end
                                ttce_pkg::HK_TAB: o_cmd.consume1 = 1'b1;
                                ttce_pkg::HK_BS: begin
                                    o_cmd.consume1 = 1'b1;
                                    if (!i_stat.fill_zero) begin
                                        o_cmd.bs_start = 1'b1;
                                        n_state        = ttce_pkg::ST_WALK;
                                    end
                                end
                                ttce_pkg::HK_OTHER: begin
                                    if (i_stat.full) begin
                                        o_cmd.consume1 = 1'b1;
                                    end else if (i_stat.slot_ok) begin
                                        o_cmd.do_glyph = 1'b1;
                                        o_cmd.consume1 = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ttce_pkg::ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    o_cmd.walk = 1'b0;
                    n_state    = ttce_pkg::ST_CLEAR;
                end
            end
            ttce_pkg::ST_CLEAR: begin
                if (i_stat.slot_ok) begin
                    o_cmd.emit_clear = 1'b1;
                    n_state          = ttce_pkg::ST_SCAN;
                end
            end
            ttce_pkg::ST_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = ttce_pkg::ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ttce_pkg::ST_IDLE;
                end
            end
            default: n_state = ttce_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/ttce_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_dp
// datapath: lookahead window, text store, cursor, colour and result registers
// ----------------------------------------------------------------------------
module ttce_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ttce_pkg::t_cmd                     i_cmd,
    output ttce_pkg::t_stat                         o_stat,
    input  wire logic [ttce_pkg::CH_W-1:0]          i_ch,
    input  wire logic                               i_last,
    input  wire logic                               i_cfg_we,
    input  wire logic [ttce_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ttce_pkg::COLOR_W-1:0]       i_cfg_data,
    ttce_out_if.source                              o_out
);
    localparam int LA = ttce_pkg::LA_LEN;

    logic [ttce_pkg::CH_W-1:0]    r_la [LA];
    logic [ttce_pkg::CNT_W-1:0]   r_count;
    logic                         r_last;
    logic [ttce_pkg::FILL_W-1:0]  r_fill;
    ttce_pkg::t_cursor            r_cur;
    logic [ttce_pkg::COLOR_W-1:0] r_color;
    logic [ttce_pkg::LS_W-1:0]    r_ls;
    logic [ttce_pkg::FILL_W-1:0]  r_wcnt;
    logic                         r_wrd;
    ttce_pkg::t_result            r_pend;
    logic                         r_pend_valid;
    ttce_pkg::t_result            r_out;
    logic                         r_out_valid;
    ttce_pkg::t_result            n_pend;
    logic                         n_pend_valid;
    ttce_pkg::t_result            n_out;
    logic                         n_out_valid;

    logic                         w_full;
    logic                         w_out_free;
    logic                         w_issue;
    logic                         w_we;
    logic [ttce_pkg::CH_W-1:0]    w_rdata;
    logic [ttce_pkg::COLOR_W-1:0] w_esc_color;
    logic [ttce_pkg::CNT_W-1:0]   w_app_idx;
    ttce_pkg::t_result            w_new;

    assign w_full     = (r_fill == ttce_pkg::FILL_W'(ttce_pkg::BUFFER_DEPTH));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_issue    = i_cmd.walk && (r_wcnt < r_fill);
    assign w_we       = (i_cmd.do_nl && !w_full) || i_cmd.do_glyph;
    assign w_app_idx  = (r_count >= ttce_pkg::CNT_W'(LA)) ? ttce_pkg::CNT_W'(LA - 1) : r_count;

    ttce_ram #(
        .WIDTH (ttce_pkg::CH_W),
        .DEPTH (ttce_pkg::BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[ttce_pkg::ADDR_W-1:0]),
        .i_wdata (r_la[0]),
        .i_raddr (r_wcnt[ttce_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // leading hex digits of an escape, at most six
    always_comb begin
        logic [4:0] hv;
        logic       stop;
        w_esc_color = '0;
        stop        = 1'b0;
        for (int j = 0; j < 6; j++) begin
            hv = ttce_pkg::hex_val(r_la[2+j]);
            if (!stop && hv[4]) begin
                w_esc_color = {w_esc_color[ttce_pkg::COLOR_W-5:0], hv[3:0]};
            end else begin
                stop = 1'b1;
            end
        end
    end

    // head decision
    always_comb begin
        o_stat            = '0;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = w_full;
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.walk_done  = !(r_wcnt < r_fill) && !r_wrd;
        o_stat.out_free   = w_out_free;
        o_stat.pend_valid = r_pend_valid;
        o_stat.slot_ok    = !r_pend_valid || w_out_free;
        o_stat.act        = ttce_pkg::ACT_CHAR;
        if (r_la[0] == ttce_pkg::CH_BSLASH && !w_full) begin
            if (r_count < ttce_pkg::CNT_W'(2)) begin
                o_stat.act = r_last ? ttce_pkg::ACT_CHAR : ttce_pkg::ACT_WAIT;
            end else if (r_la[1] != ttce_pkg::CH_LPAREN) begin
                o_stat.act = ttce_pkg::ACT_CHAR;
            end else if (r_count < ttce_pkg::CNT_W'(LA)) begin
                o_stat.act = r_last ? ttce_pkg::ACT_DROP : ttce_pkg::ACT_WAIT;
            end else if (r_la[LA-1] == ttce_pkg::CH_RPAREN) begin
                o_stat.act = ttce_pkg::ACT_COLOR;
            end else begin
                o_stat.act = ttce_pkg::ACT_DROP;
            end
        end
        if (r_la[0] == ttce_pkg::CH_NL) begin
            o_stat.head_kind = ttce_pkg::HK_NL;
        end else if (r_la[0] == ttce_pkg::CH_BS) begin
            o_stat.head_kind = ttce_pkg::HK_BS;
        end else if (r_la[0] == ttce_pkg::CH_TAB) begin
            o_stat.head_kind = ttce_pkg::HK_TAB;
        end else begin
            o_stat.head_kind = ttce_pkg::HK_OTHER;
        end
    end

    always_comb begin
        w_new.kind        = i_cmd.emit_clear ? ttce_pkg::KIND_CLEAR : ttce_pkg::KIND_GLYPH;
        w_new.x_pos       = r_cur.x;
        w_new.y_pos       = r_cur.y;
        w_new.glyph       = i_cmd.emit_clear ? '0 : r_la[0];
        w_new.color       = i_cmd.emit_clear ? '0 : r_color;
        w_new.last_result = 1'b0;
    end

    // pending and output result registers
    always_comb begin
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !(o_out.valid && o_out.ready);
        if (i_cmd.do_glyph || i_cmd.emit_clear) begin
            n_pend       = w_new;
            n_pend_valid = 1'b1;
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out_valid = 1'b1;
            end
        end
        if (i_cmd.flush) begin
            n_out             = r_pend;
            n_out.last_result = 1'b1;
            n_out_valid       = 1'b1;
            n_pend_valid      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LA; i++) begin
                r_la[i] <= '0;
            end
            r_count      <= '0;
            r_last       <= 1'b0;
            r_fill       <= '0;
            r_cur        <= '0;
            r_color      <= ttce_pkg::COLOR_RESET;
            r_ls         <= ttce_pkg::LS_RESET;
            r_wcnt       <= '0;
            r_wrd        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ttce_pkg::CFG_LINE_SPACING) begin
                    r_ls <= i_cfg_data[ttce_pkg::LS_W-1:0];
                end else if (i_cfg_idx == ttce_pkg::CFG_DEFAULT_COLOR) begin
                    r_color <= i_cfg_data;
                end
            end

            if (i_cmd.append) begin
                r_la[w_app_idx] <= i_ch;
                r_count         <= w_app_idx + ttce_pkg::CNT_W'(1);
                r_last          <= i_last;
            end
            if (i_cmd.consume1) begin
                for (int i = 0; i < LA - 1; i++) begin
                    r_la[i] <= r_la[i+1];
                end
                r_la[LA-1] <= '0;
                r_count    <= r_count - ttce_pkg::CNT_W'(1);
            end
            if (i_cmd.consume_all) begin
                for (int i = 0; i < LA; i++) begin
                    r_la[i] <= '0;
                end
                r_count <= '0;
            end
            if (i_cmd.load_color) begin
                r_color <= w_esc_color;
            end

            if (i_cmd.do_nl) begin
                r_cur <= ttce_pkg::step_cursor(r_cur, 1'b1, r_ls);
                if (!w_full) begin
                    r_fill <= r_fill + ttce_pkg::FILL_W'(1);
                end
            end
            if (i_cmd.do_glyph) begin
                r_cur  <= ttce_pkg::step_cursor(r_cur, 1'b0, r_ls);
                r_fill <= r_fill + ttce_pkg::FILL_W'(1);
            end

            // backspace: drop last byte, rebuild cursor from the stored text
            if (i_cmd.bs_start) begin
                r_fill <= r_fill - ttce_pkg::FILL_W'(1);
                r_cur  <= '0;
                r_wcnt <= '0;
                r_wrd  <= 1'b0;
            end
            if (i_cmd.walk) begin
                r_wrd <= w_issue;
                if (w_issue) begin
                    r_wcnt <= r_wcnt + ttce_pkg::FILL_W'(1);
                end
                if (r_wrd) begin
                    r_cur <= ttce_pkg::step_cursor(r_cur, (w_rdata == ttce_pkg::CH_NL), r_ls);
                end
            end

            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_out        <= n_out;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.x_pos       = r_out.x_pos;
    assign o_out.y_pos       = r_out.y_pos;
    assign o_out.glyph       = r_out.glyph;
    assign o_out.color       = r_out.color;
    assign o_out.last_result = r_out.last_result;
endmodule
`default_nettype wire

// ===== rtl/text_terminal_cursor_engine.sv =====
`default_nettype none
// an ordinary character is appended to the window, registered as the pending result, then moved to the output
// a new input beat is taken only in idle, after the window has been handled and any pending result flushed
// backspace adds a walk over the stored text, one text store read per cycle
// a held colour escape waits in the 11-byte window until decided
// reset: synchronous active low; cursor, fill, window, valid flags cleared; no store sweep
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// turns a character stream into draw and clear commands at a wrapping cursor
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ttce_in_if.sink                             i_in,
    ttce_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [ttce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ttce_pkg::COLOR_W-1:0]   i_cfg_data
);
    // command and status between sequencer and datapath
    ttce_pkg::t_cmd  w_cmd;
    ttce_pkg::t_stat w_stat;
    logic            w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer: one window head per cycle, except during a backspace walk or while the result slots are full
    ttce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: the pending result register lets the final beat carry last_result
    ttce_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_ch       (i_in.ch),
        .i_last     (i_in.last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

    // a new result never overwrites a pending one that cannot move on
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.do_glyph || w_cmd.emit_clear) |-> w_stat.slot_ok)
        else $error("result pushed with no free slot");

    // backspace walk only starts with stored text
    a_bs_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.bs_start |-> !w_stat.fill_zero)
        else $error("backspace walk on empty store");

    // one beat at a time: ready drops right after an accepted beat
    a_seq_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while busy");
endmodule
`default_nettype wire
